// ===== rtl/queue_with_remove_by_key_defines.svh =====
// Assertion macros for the queue with remove by key.
// Simulation gets concurrent assertions; synthesis sees empty bodies.
`ifndef QUEUE_WITH_REMOVE_BY_KEY_DEFINES_SVH
`define QUEUE_WITH_REMOVE_BY_KEY_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define QRK_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define QRK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define QRK_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define QRK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/qrk_pkg.sv =====
`default_nettype none

package qrk_pkg;

    // Default sizing
    localparam int DEPTH_DEFAULT    = 16;
    localparam int KEY_BITS_DEFAULT = 32;

    // Fixed field widths
    localparam int MODE_BITS   = 2;
    localparam int KEY_IO_BITS = 32;
    localparam int AGE_BITS    = 8;
    localparam int STAT_BITS   = 3;
    localparam int OCC_BITS    = 5;

    // Operation codes
    localparam logic [MODE_BITS-1:0] MODE_PUSH   = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_SERVE  = 2'd2;

    // Result status codes
    localparam logic [STAT_BITS-1:0] STAT_PUSHED    = 3'd0;
    localparam logic [STAT_BITS-1:0] STAT_FULL      = 3'd1;
    localparam logic [STAT_BITS-1:0] STAT_REMOVED   = 3'd2;
    localparam logic [STAT_BITS-1:0] STAT_NOT_FOUND = 3'd3;
    localparam logic [STAT_BITS-1:0] STAT_SERVED    = 3'd4;
    localparam logic [STAT_BITS-1:0] STAT_EMPTY     = 3'd5;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT,
        ST_RESULT
    } qrk_state_t;

endpackage

`default_nettype wire

// ===== rtl/queue_with_remove_by_key.sv =====
// Ordered queue of up to DEPTH entries (key plus 8-bit age) held in one
// single-port-read, single-port-write memory, head at address 0. Push, a push
// that finds the queue full, and a remove or serve on an empty queue go from
// acceptance straight to the result state and load the output register from
// there once it is free. For remove and serve the memory delivers one entry
// per cycle, first while the key is compared from the head, then while every
// later entry is moved one address forward. Serve is a removal at the head.
// One transaction is in work at a time; the next is accepted in the cycle
// after the result has moved to the output register. Mode 3 is accepted and
// dropped. Keys are compared and stored on their low KEY_BITS bits.
// Occupancy wraps modulo 32 when DEPTH is above 31. The memory needs no
// clearing after reset.
`default_nettype none

`include "queue_with_remove_by_key_defines.svh"

module queue_with_remove_by_key #(
    parameter int DEPTH    = qrk_pkg::DEPTH_DEFAULT,
    parameter int KEY_BITS = qrk_pkg::KEY_BITS_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // request channel
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [qrk_pkg::MODE_BITS-1:0]   mode,
    input  wire logic [qrk_pkg::KEY_IO_BITS-1:0] key,
    input  wire logic [qrk_pkg::AGE_BITS-1:0]    age,
    // result channel
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [qrk_pkg::STAT_BITS-1:0]        status,
    output logic [qrk_pkg::KEY_IO_BITS-1:0]      served_key,
    output logic [qrk_pkg::AGE_BITS-1:0]         served_age,
    output logic [qrk_pkg::OCC_BITS-1:0]         occupancy
);

    import qrk_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = KEY_BITS + AGE_BITS;

    // Entry memory
    logic [EW-1:0] mem [DEPTH];
    logic [EW-1:0] rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    // Control and working registers
    qrk_state_t              state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [AW-1:0]           idx_reg, idx_next;
    logic [MODE_BITS-1:0]    op_reg, op_next;
    logic [KEY_BITS-1:0]     key_reg, key_next;
    logic [STAT_BITS-1:0]    res_status_reg, res_status_next;
    logic [KEY_IO_BITS-1:0]  res_key_reg, res_key_next;
    logic [AGE_BITS-1:0]     res_age_reg, res_age_next;

    // Output register
    logic                    out_valid_reg, out_valid_next;
    logic [STAT_BITS-1:0]    status_reg;
    logic [KEY_IO_BITS-1:0]  served_key_reg;
    logic [AGE_BITS-1:0]     served_age_reg;
    logic [OCC_BITS-1:0]     occupancy_reg;

    // Helpers
    logic                    in_accept;
    logic                    out_load;
    logic                    is_full;
    logic                    is_empty;
    logic [KEY_BITS-1:0]     rd_key;
    logic [AGE_BITS-1:0]     rd_age;
    logic                    hit;
    logic [CW-1:0]           idx_p1;
    logic [CW-1:0]           idx_p2;
    logic                    more;
    logic                    more2;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_load  = (state_reg == ST_RESULT) && (!out_valid_reg || !out_stall);
    assign is_full   = (count_reg == CW'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign rd_key    = rd_data_reg[EW-1:AGE_BITS];
    assign rd_age    = rd_data_reg[AGE_BITS-1:0];
    assign hit       = (op_reg == MODE_SERVE) || (rd_key == key_reg);
    assign idx_p1    = CW'(idx_reg) + CW'(1);
    assign idx_p2    = CW'(idx_reg) + CW'(2);
    assign more      = (idx_p1 < count_reg);
    assign more2     = (idx_p2 < count_reg);

    // Memory: at most one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if ((mode == MODE_REMOVE || mode == MODE_SERVE) && !is_empty)
                    begin
                        state_next = ST_SEARCH;
                    end
                    else if (mode == MODE_PUSH || mode == MODE_REMOVE ||
                             mode == MODE_SERVE)
                    begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (hit && more)
                begin
                    state_next = ST_SHIFT;
                end
                else if (!more)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_SHIFT:
            begin
                if (!more2)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        rd_addr         = idx_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = rd_data_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        res_age_next    = res_age_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_next      = mode;
                    key_next     = KEY_BITS'(key);
                    idx_next     = '0;
                    rd_addr      = '0;
                    res_key_next = '0;
                    res_age_next = '0;
                    case (mode)
                        MODE_PUSH:
                        begin
                            if (is_full)
                            begin
                                res_status_next = STAT_FULL;
                            end
                            else
                            begin
                                wr_en           = 1'b1;
                                wr_addr         = AW'(count_reg);
                                wr_data         = {KEY_BITS'(key), age};
                                count_next      = count_reg + CW'(1);
                                res_status_next = STAT_PUSHED;
                            end
                        end
                        MODE_REMOVE:
                        begin
                            res_status_next = STAT_NOT_FOUND;
                        end
                        MODE_SERVE:
                        begin
                            res_status_next = STAT_EMPTY;
                        end
                        default:
                        begin
                            res_status_next = res_status_reg;
                        end
                    endcase
                end
            end
            ST_SEARCH:
            begin
                // rd_data_reg holds entry idx_reg
                if (hit)
                begin
                    if (op_reg == MODE_SERVE)
                    begin
                        res_status_next = STAT_SERVED;
                        res_key_next    = KEY_IO_BITS'(rd_key);
                        res_age_next    = rd_age;
                    end
                    else
                    begin
                        res_status_next = STAT_REMOVED;
                    end
                    if (more)
                    begin
                        rd_addr = AW'(idx_p1);
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
                else if (more)
                begin
                    rd_addr  = AW'(idx_p1);
                    idx_next = AW'(idx_p1);
                end
                else
                begin
                    res_status_next = STAT_NOT_FOUND;
                end
            end
            ST_SHIFT:
            begin
                // rd_data_reg holds entry idx_reg + 1; move it to idx_reg
                wr_en    = 1'b1;
                wr_addr  = idx_reg;
                wr_data  = rd_data_reg;
                idx_next = AW'(idx_p1);
                if (more2)
                begin
                    rd_addr = AW'(idx_p2);
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            ST_RESULT:
            begin
                rd_addr = idx_reg;
            end
            default:
            begin
                rd_addr = idx_reg;
            end
        endcase
    end

    // Output valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        op_reg         <= op_next;
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_key_reg    <= res_key_next;
        res_age_reg    <= res_age_next;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg     <= res_status_reg;
            served_key_reg <= res_key_reg;
            served_age_reg <= res_age_reg;
            occupancy_reg  <= OCC_BITS'(count_reg);
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign served_key = served_key_reg;
    assign served_age = served_age_reg;
    assign occupancy  = occupancy_reg;

    // Assertions
    `QRK_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(DEPTH),
                     "count above depth")
    `QRK_ASSERT_IMPL(a_shift_range, clk, rst_n, state_reg == ST_SHIFT, more,
                     "shift past tail")
    `QRK_ASSERT_IMPL(a_zero_payload, clk, rst_n, out_valid && status != STAT_SERVED,
                     served_key == '0 && served_age == '0,
                     "served data on non-serve result")
    `QRK_ASSERT_NEXT(a_push_count, clk, rst_n, in_accept && mode == MODE_PUSH && !is_full,
                     count_reg == $past(count_reg) + CW'(1),
                     "push did not advance count")

endmodule

`default_nettype wire

// ===== test/queue_result_checker.sv =====
`default_nettype none

// Watches both channels of the queue, predicts each result from the accepted
// requests and compares the results in arrival order.
module queue_result_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    input  wire logic                            in_stall,
    input  wire logic [qrk_pkg::MODE_BITS-1:0]   mode,
    input  wire logic [qrk_pkg::KEY_IO_BITS-1:0] key,
    input  wire logic [qrk_pkg::AGE_BITS-1:0]    age,
    input  wire logic                            out_valid,
    input  wire logic                            out_stall,
    input  wire logic [qrk_pkg::STAT_BITS-1:0]   status,
    input  wire logic [qrk_pkg::KEY_IO_BITS-1:0] served_key,
    input  wire logic [qrk_pkg::AGE_BITS-1:0]    served_age,
    input  wire logic [qrk_pkg::OCC_BITS-1:0]    occupancy,
    output int                                   fail_count,
    output int                                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import qrk_pkg::*;

    localparam int DEPTH    = DEPTH_DEFAULT;
    localparam int KEY_BITS = KEY_BITS_DEFAULT;
    localparam logic [KEY_IO_BITS-1:0] KEY_MASK =
        (KEY_BITS >= KEY_IO_BITS) ? '1 : ((KEY_IO_BITS'(1) << KEY_BITS) - 1);

    typedef struct packed {
        logic [STAT_BITS-1:0]   status;
        logic [KEY_IO_BITS-1:0] served_key;
        logic [AGE_BITS-1:0]    served_age;
        logic [OCC_BITS-1:0]    occupancy;
    } queue_result_t;

    // Shadow copy of the queue contents, head at index 0
    logic [KEY_IO_BITS-1:0] held_keys [DEPTH];
    logic [AGE_BITS-1:0]    held_ages [DEPTH];
    int                     held_count;

    queue_result_t expected_results[$];
    int            status_seen [8];
    int            peak_occupancy;

    initial
    begin
        fail_count     = 0;
        pending        = 0;
        held_count     = 0;
        peak_occupancy = 0;
        foreach (status_seen[i])
            status_seen[i] = 0;
    end

    // Drop one entry and pull every later entry one place toward the head
    task automatic drop_entry(input int pos);
        for (int i = pos; i + 1 < held_count; i++)
        begin
            held_keys[i] = held_keys[i + 1];
            held_ages[i] = held_ages[i + 1];
        end
        held_count--;
    endtask

    task automatic predict_request(input logic [MODE_BITS-1:0] m,
                                   input logic [KEY_IO_BITS-1:0] k,
                                   input logic [AGE_BITS-1:0] a);
        queue_result_t r;
        int            hit;
        r   = '0;
        hit = -1;
        case (m)
            MODE_PUSH:
            begin
                if (held_count >= DEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    held_keys[held_count] = k & KEY_MASK;
                    held_ages[held_count] = a;
                    held_count++;
                    r.status = STAT_PUSHED;
                end
            end
            MODE_REMOVE:
            begin
                // first match from the head wins; every held entry is searched
                for (int i = 0; i < held_count; i++)
                begin
                    if (hit < 0 && held_keys[i] == (k & KEY_MASK))
                        hit = i;
                end
                if (hit >= 0)
                begin
                    drop_entry(hit);
                    r.status = STAT_REMOVED;
                end
                else
                    r.status = STAT_NOT_FOUND;
            end
            MODE_SERVE:
            begin
                if (held_count == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    r.served_key = held_keys[0];
                    r.served_age = held_ages[0];
                    drop_entry(0);
                    r.status = STAT_SERVED;
                end
            end
            default:
                return;    // unused mode is dropped without a result
        endcase
        r.occupancy = OCC_BITS'(held_count);
        if (held_count > peak_occupancy)
            peak_occupancy = held_count;
        expected_results.push_back(r);
    endtask

    function automatic void compare_field(input string name,
                                          input logic [KEY_IO_BITS-1:0] want,
                                          input logic [KEY_IO_BITS-1:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Sample both channels at the rising edge
    always @(posedge clk)
    begin
        queue_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transaction with no request outstanding, status %0d",
                           status);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("status", KEY_IO_BITS'(want.status),
                                  KEY_IO_BITS'(status));
                    compare_field("served_key", want.served_key, served_key);
                    compare_field("served_age", KEY_IO_BITS'(want.served_age),
                                  KEY_IO_BITS'(served_age));
                    compare_field("occupancy", KEY_IO_BITS'(want.occupancy),
                                  KEY_IO_BITS'(occupancy));
                    status_seen[want.status]++;
                end
            end
            if (in_valid && !in_stall)
                predict_request(mode, key, age);
            pending = expected_results.size();
        end
    end

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import qrk_pkg::*;

    localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;
    localparam int RANDOM_REQUESTS = 500;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_CYCLES     = 400;
    localparam int HOLD_AFTER      = 60;
    localparam int DRAIN_CYCLES    = 60;
    localparam logic [KEY_IO_BITS-1:0] DUP_KEY  = 32'hA5A5_0F0F;
    localparam logic [KEY_IO_BITS-1:0] KEY_BASE = 32'h1234_5600;
    localparam logic [KEY_IO_BITS-1:0] MISS_KEY = 32'h5A5A_A5A5;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [MODE_BITS-1:0]   mode;
    logic [KEY_IO_BITS-1:0] key;
    logic [AGE_BITS-1:0]    age;
    logic                   out_valid;
    logic                   out_stall;
    logic [STAT_BITS-1:0]   status;
    logic [KEY_IO_BITS-1:0] served_key;
    logic [AGE_BITS-1:0]    served_age;
    logic [OCC_BITS-1:0]    occupancy;
    int                     fail_count;
    int                     pending;
    int                     cycle_count;
    int                     requests_sent;
    int                     results_taken;
    bit                     quiet_sender;
    bit                     hold_done;

    queue_with_remove_by_key DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .key        (key),
        .age        (age),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .served_key (served_key),
        .served_age (served_age),
        .occupancy  (occupancy)
    );

    queue_result_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .key        (key),
        .age        (age),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .served_key (served_key),
        .served_age (served_age),
        .occupancy  (occupancy),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Clock and reset
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
    end

    // Run limit
    initial
        cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending);
            $display("queue_with_remove_by_key verification failed");
            $finish;
        end
    end

    // Offer one request transaction after a random gap (none while quiet_sender is set); returns on a negedge
    task automatic send_request(input logic [MODE_BITS-1:0] m,
                                input logic [KEY_IO_BITS-1:0] k,
                                input logic [AGE_BITS-1:0] a);
        int unsigned gap;
        gap = quiet_sender ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        mode     = m;
        key      = k;
        age      = a;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        requests_sent++;
    endtask

    // Result side: random stall per transaction in two of every three runs of 50 results, plus one long hold-off
    initial
    begin
        int unsigned wait_cycles;
        out_stall     = 1'b1;
        results_taken = 0;
        hold_done     = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!hold_done && results_taken >= HOLD_AFTER)
            begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            wait_cycles = ((results_taken / 50) % 3 == 0) ? 0 : $urandom_range(0, 16);
            if (wait_cycles > 0)
            begin
                out_stall = 1'b1;
                repeat (wait_cycles) @(negedge clk);
            end
            out_stall = 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            results_taken++;
            @(negedge clk);
        end
    end

    // Request side: directed cases, then random traffic
    initial
    begin
        logic [KEY_IO_BITS-1:0] key_pool [8];
        logic [KEY_IO_BITS-1:0] pick_key;
        int                     counted;
        int unsigned            roll;
        int unsigned            push_share;

        in_valid      = 1'b0;
        mode          = MODE_PUSH;
        key           = '0;
        age           = '0;
        requests_sent = 0;
        quiet_sender  = 1'b1;
        @(posedge rst_n);
        @(negedge clk);

        // empty queue, unused mode, extreme keys and ages
        send_request(MODE_SERVE, '0, '0);
        send_request(MODE_REMOVE, MISS_KEY, '0);
        send_request(MODE_UNUSED, '1, '1);
        send_request(MODE_PUSH, '0, '0);
        send_request(MODE_PUSH, '1, '1);
        // duplicate keys, then fill to capacity
        send_request(MODE_PUSH, DUP_KEY, 8'h11);
        send_request(MODE_PUSH, DUP_KEY, 8'h22);
        for (int i = 0; i < 12; i++)
            send_request(MODE_PUSH, KEY_BASE + i, AGE_BITS'(8'h40 + i));
        send_request(MODE_PUSH, MISS_KEY, 8'h77);
        // match at the tail, nearest duplicate, no match, head pop
        send_request(MODE_REMOVE, KEY_BASE + 11, '0);
        send_request(MODE_REMOVE, DUP_KEY, '0);
        send_request(MODE_REMOVE, MISS_KEY, '0);
        send_request(MODE_SERVE, '0, '0);

        // Random traffic over a small key pool so that removes often hit
        foreach (key_pool[i])
            key_pool[i] = $urandom();
        counted = 0;
        while (counted < RANDOM_REQUESTS)
        begin
            quiet_sender = ((counted / 40) % 4 == 0);
            push_share   = ((counted / 60) % 2 == 0) ? 65 : 30;
            pick_key     = key_pool[$urandom_range(0, 7)];
            roll         = $urandom_range(0, 99);
            if (roll < 5)
            begin
                send_request(MODE_UNUSED, $urandom(), AGE_BITS'($urandom()));
            end
            else if (roll < 5 + push_share)
            begin
                if ($urandom_range(0, 3) == 0)
                    key_pool[$urandom_range(0, 7)] = $urandom();
                send_request(MODE_PUSH, pick_key, AGE_BITS'($urandom()));
                counted++;
            end
            else if (roll < 5 + push_share + (95 - push_share) / 2)
            begin
                if ($urandom_range(0, 6) == 0)
                    pick_key = $urandom();
                send_request(MODE_REMOVE, pick_key, AGE_BITS'($urandom()));
                counted++;
            end
            else
            begin
                send_request(MODE_SERVE, $urandom(), AGE_BITS'($urandom()));
                counted++;
            end
        end
        in_valid = 1'b0;

        // Drain
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d requests sent, %0d results checked, peak occupancy %0d",
                 requests_sent, results_taken, chk.peak_occupancy);
        $display("statuses: %0d pushed, %0d full, %0d removed, %0d not found, %0d served, %0d empty",
                 chk.status_seen[STAT_PUSHED], chk.status_seen[STAT_FULL],
                 chk.status_seen[STAT_REMOVED], chk.status_seen[STAT_NOT_FOUND],
                 chk.status_seen[STAT_SERVED], chk.status_seen[STAT_EMPTY]);
        if (fail_count == 0 && pending == 0)
            $display("queue_with_remove_by_key verification clean");
        else
            $display("queue_with_remove_by_key verification failed");
        $finish;
    end

endmodule

`default_nettype wire
